// ----- hdl/mctl_pkg.sv -----
// Package for the minimum-cost tree block: field widths, defaults, the
// control struct between the top level and the span engine, width helpers.
// No dependencies.
package mctl_pkg;

    localparam int LEAF_W          = 8;
    localparam int COST_W          = 21;
    localparam int COST_MAX        = 2097151;
    localparam int MAX_LEAVES_DEF  = 32;
    localparam int LEAF_BITS_DEF   = 8;

    typedef struct packed {
        logic start;
        logic leaf_we;
    } t_eng_ctrl;

    function automatic int val_width(input int lb);
        return (lb < LEAF_W) ? lb : LEAF_W;
    endfunction

    function automatic int cost_width(input int m, input int vw);
        longint mx;
        int     w;
        mx = longint'(m - 1) * ((longint'(1) << vw) - 1) * ((longint'(1) << vw) - 1);
        w  = $clog2(mx + 1);
        return (w > 2 * vw) ? w : 2 * vw;
    endfunction

endpackage

// ----- hdl/mctl_if.sv -----
// Handshake channels of the minimum-cost tree block: leaf input and cost
// result. Depends on mctl_pkg.
interface mctl_leaf_if;
    import mctl_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEAF_W-1:0] leaf_value;
    logic              last_leaf;

    modport source (output valid, leaf_value, last_leaf, input ready);
    modport sink   (input valid, leaf_value, last_leaf, output ready);
endinterface

interface mctl_cost_if;
    import mctl_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] min_cost;
    logic              overflowed;

    modport source (output valid, min_cost, overflowed, input ready);
    modport sink   (input valid, min_cost, overflowed, output ready);
endinterface

// ----- hdl/mctl_dp_engine.sv -----
// Span engine: holds the span-maximum and span-cost memories, builds the
// maximum table and runs the interval dynamic program. Depends on mctl_pkg.
module mctl_dp_engine #(
    parameter int MAX_LEAVES = mctl_pkg::MAX_LEAVES_DEF,
    parameter int LEAF_BITS  = mctl_pkg::LEAF_BITS_DEF
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  mctl_pkg::t_eng_ctrl                                       i_ctrl,
    input  logic [$clog2(MAX_LEAVES)-1:0]                             i_leaf_idx,
    input  logic [mctl_pkg::val_width(LEAF_BITS)-1:0]                 i_leaf_val,
    input  logic [$clog2(MAX_LEAVES+1)-1:0]                           i_n,
    output logic                                                      o_done,
    output logic [mctl_pkg::cost_width(MAX_LEAVES,
                  mctl_pkg::val_width(LEAF_BITS))-1:0]                o_cost
);
    import mctl_pkg::*;

    localparam int IW    = $clog2(MAX_LEAVES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int VAL_W = val_width(LEAF_BITS);
    localparam int CW    = cost_width(MAX_LEAVES, VAL_W);

    typedef enum logic [5:0] {
        E_IDLE   = 6'b000001,
        E_MX_RD  = 6'b000010,
        E_MX_WR  = 6'b000100,
        E_DP_ISS = 6'b001000,
        E_DP_DRN = 6'b010000,
        E_FIN    = 6'b100000
    } t_state;

    t_state            r_state;
    logic [IW-1:0]     r_l, r_r, r_s, r_nl;
    logic [VAL_W-1:0]  r_max_mem [DEPTH];
    logic [CW-1:0]     r_cost_mem [DEPTH];
    logic [VAL_W-1:0]  r_ma, r_mb;
    logic [CW-1:0]     r_ca, r_cb;
    logic              r_p1_v, r_p1_ld, r_p1_rd;
    logic              r_p2_v, r_p2_first, r_p2_last;
    logic [2*VAL_W-1:0] r_p2_prod;
    logic [CW-1:0]     r_p2_csum;
    logic [CW-1:0]     r_best;
    logic [CW-1:0]     r_cost;

    logic [IW-1:0]     s_next;
    logic [AW-1:0]     max_ra_a, max_ra_b, max_wa, cost_wa;
    logic              max_we, cost_we;
    logic [VAL_W-1:0]  max_wd, mx;
    logic [CW-1:0]     csum, tot, cand;

    assign s_next = r_s + IW'(1);
    assign mx     = (r_ma > r_mb) ? r_ma : r_mb;

    always_comb begin
        if (r_state == E_MX_RD) begin
            max_ra_a = {r_r, r_r};
            max_ra_b = {r_l, IW'(r_r - IW'(1))};
        end else begin
            max_ra_a = {r_l, r_s};
            max_ra_b = {s_next, r_r};
        end
    end

    assign max_we = i_ctrl.leaf_we || (r_state == E_MX_WR);
    assign max_wa = i_ctrl.leaf_we ? {i_leaf_idx, i_leaf_idx} : {r_l, r_r};
    assign max_wd = i_ctrl.leaf_we ? i_leaf_val : mx;

    assign csum = (r_p1_ld ? CW'(0) : r_ca) + (r_p1_rd ? CW'(0) : r_cb);
    assign tot  = CW'(r_p2_prod) + r_p2_csum;
    assign cand = (r_p2_first || (tot < r_best)) ? tot : r_best;

    assign cost_we = r_p2_v && r_p2_last;
    assign cost_wa = {r_l, r_r};

    always_ff @(posedge i_clk) begin
        if (max_we) begin
            r_max_mem[max_wa] <= max_wd;
        end
        r_ma <= r_max_mem[max_ra_a];
        r_mb <= r_max_mem[max_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            r_cost_mem[cost_wa] <= cand;
        end
        r_ca <= r_cost_mem[{r_l, r_s}];
        r_cb <= r_cost_mem[{s_next, r_r}];
    end

    always_ff @(posedge i_clk) begin
        r_p1_ld    <= (r_s == r_l);
        r_p1_rd    <= (s_next == r_r);
        r_p2_first <= r_p1_ld;
        r_p2_last  <= r_p1_rd;
        r_p2_prod  <= r_ma * r_mb;
        r_p2_csum  <= csum;
        if (r_p2_v) begin
            r_best <= cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
        end else begin
            r_p1_v <= (r_state == E_DP_ISS);
            r_p2_v <= r_p1_v;
            case (r_state)
                E_IDLE: begin
                    if (i_ctrl.start) begin
                        r_nl    <= IW'(i_n - 1'b1);
                        r_l     <= '0;
                        r_r     <= IW'(1);
                        r_state <= E_MX_RD;
                    end
                end
                E_MX_RD: begin
                    r_state <= E_MX_WR;
                end
                E_MX_WR: begin
                    if (r_r == r_nl) begin
                        if (r_l == IW'(r_nl - IW'(1))) begin
                            r_s     <= r_l;
                            r_state <= E_DP_ISS;
                        end else begin
                            r_l     <= r_l + IW'(1);
                            r_r     <= r_l + IW'(2);
                            r_state <= E_MX_RD;
                        end
                    end else begin
                        r_r     <= r_r + IW'(1);
                        r_state <= E_MX_RD;
                    end
                end
                E_DP_ISS: begin
                    if (s_next == r_r) begin
                        r_state <= E_DP_DRN;
                    end else begin
                        r_s <= s_next;
                    end
                end
                E_DP_DRN: begin
                    if (r_p2_v && r_p2_last) begin
                        if (r_r == r_nl) begin
                            if (r_l == '0) begin
                                r_cost  <= cand;
                                r_state <= E_FIN;
                            end else begin
                                r_l     <= r_l - IW'(1);
                                r_r     <= r_l;
                                r_s     <= r_l - IW'(1);
                                r_state <= E_DP_ISS;
                            end
                        end else begin
                            r_r     <= r_r + IW'(1);
                            r_s     <= r_l;
                            r_state <= E_DP_ISS;
                        end
                    end
                end
                E_FIN: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == E_FIN);
    assign o_cost = r_cost;

endmodule

// ----- hdl/min_cost_tree_from_leaves_core.sv -----
// Top level of the minimum-cost tree block: leaf loading, set control and
// the result register. Depends on mctl_pkg, mctl_if and mctl_dp_engine.
//
// Leaves are taken one per cycle and written straight into the diagonal of
// the span-maximum memory; up to MAX_LEAVES are kept, later ones are dropped
// and flagged in the result. The transaction that carries the last leaf
// starts the computation and the input stays stalled until the result has
// moved to the output register. For n stored leaves the block first builds
// the maximum table, reading and then writing each span, then runs the
// dynamic program one span at a time: one split point is read from the
// two memory ports per cycle, and a span's cost is written back before the
// next span may read it. The cost then passes through the engine's cost
// register and the result register to the output register, provided the
// output register is free. A set of one leaf bypasses the engine and its
// zero cost goes straight to the result register.
module min_cost_tree_from_leaves_core #(
    parameter int MAX_LEAVES = mctl_pkg::MAX_LEAVES_DEF,
    parameter int LEAF_BITS  = mctl_pkg::LEAF_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mctl_leaf_if.sink   i_leaf,
    mctl_cost_if.source o_cost
);
    import mctl_pkg::*;

    localparam int IW    = $clog2(MAX_LEAVES);
    localparam int CNT_W = $clog2(MAX_LEAVES + 1);
    localparam int VAL_W = val_width(LEAF_BITS);
    localparam int CW    = cost_width(MAX_LEAVES, VAL_W);
    localparam int XW    = (CW > COST_W) ? CW : COST_W;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovf;
    logic [COST_W-1:0]  r_res_cost;
    logic               r_res_ovf;
    logic               r_out_valid;
    logic [COST_W-1:0]  r_out_cost;
    logic               r_out_ovf;

    logic               in_acc, out_acc, full;
    logic [CNT_W-1:0]   n_set;
    t_eng_ctrl          eng_ctrl;
    logic               eng_done;
    logic [CW-1:0]      eng_cost;
    logic [XW-1:0]      cost_x;
    logic [COST_W-1:0]  cost_sat;

    assign in_acc  = i_leaf.valid && i_leaf.ready;
    assign out_acc = r_out_valid && o_cost.ready;
    assign full    = (r_cnt == CNT_W'(MAX_LEAVES));
    assign n_set   = full ? r_cnt : r_cnt + CNT_W'(1);

    assign i_leaf.ready     = (r_state == S_LOAD);
    assign eng_ctrl.leaf_we = in_acc && !full;
    assign eng_ctrl.start   = in_acc && i_leaf.last_leaf && (n_set > CNT_W'(1));

    assign cost_x   = XW'(eng_cost);
    assign cost_sat = (cost_x > XW'(COST_MAX)) ? COST_W'(COST_MAX) : cost_x[COST_W-1:0];

    mctl_dp_engine #(
        .MAX_LEAVES (MAX_LEAVES),
        .LEAF_BITS  (LEAF_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (eng_ctrl),
        .i_leaf_idx (r_cnt[IW-1:0]),
        .i_leaf_val (i_leaf.leaf_value[VAL_W-1:0]),
        .i_n        (n_set),
        .o_done     (eng_done),
        .o_cost     (eng_cost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_leaf.last_leaf) begin
                            r_res_ovf <= r_ovf || full;
                            r_cnt     <= '0;
                            r_ovf     <= 1'b0;
                            if (n_set > CNT_W'(1)) begin
                                r_state <= S_RUN;
                            end else begin
                                r_res_cost <= '0;
                                r_state    <= S_HOLD;
                            end
                        end else if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                S_RUN: begin
                    if (eng_done) begin
                        r_res_cost <= cost_sat;
                        r_state    <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_cost  <= r_res_cost;
                        r_out_ovf   <= r_res_ovf;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_cost.valid      = r_out_valid;
    assign o_cost.min_cost   = r_out_cost;
    assign o_cost.overflowed = r_out_ovf;

endmodule

// ----- hdl/mctl_checker.sv -----
// Port-level checks for the minimum-cost tree block, with the bind that
// attaches them to the top level. Depends on mctl_pkg and mctl_if.
module mctl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [mctl_pkg::COST_W-1:0] i_out_cost,
    input logic        i_out_ovf
);
    logic       in_last_acc, out_acc;
    logic [1:0] r_open;

    assign in_last_acc = i_in_valid && i_in_ready && i_in_last;
    assign out_acc     = i_out_valid && i_out_ready;

    // Count of closed sets whose result transaction is still to come.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, in_last_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cost)
                                        && $stable(i_out_ovf))
        else $error("result changed or vanished while stalled");

    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_last_acc |=> !i_in_ready)
        else $error("input not stalled after the last leaf");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 2'd0)
        else $error("result shown without a closed set");

    a_two_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_last_acc |-> r_open < 2'd2)
        else $error("more than two sets open at once");

endmodule

bind min_cost_tree_from_leaves_core mctl_checker u_mctl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_leaf.valid),
    .i_in_ready  (i_leaf.ready),
    .i_in_last   (i_leaf.last_leaf),
    .i_out_valid (o_cost.valid),
    .i_out_ready (o_cost.ready),
    .i_out_cost  (o_cost.min_cost),
    .i_out_ovf   (o_cost.overflowed)
);
